[design/fit_policy_block_allocator_top_defines.svh]
// Assertion macros for the fit-policy block allocator.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while reset is low.
`define FPBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while reset is low.
`define FPBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/fpba_pkg.sv]
// Package for the fit-policy block allocator: codes, field layout, states.
package fpba_pkg;

    // default geometry
    localparam int NUM_SLOTS_DEF = 64;
    localparam int SIZE_BITS_DEF = 16;

    // field widths
    localparam int REQ_W    = 2;
    localparam int IDX_F_W  = 6;
    localparam int AMT_F_W  = 16;
    localparam int MODE_W   = 2;
    localparam int WASTE_F_W = 16;
    localparam int TOTAL_W  = 32;

    // input word layout
    localparam int IN_DATA_W = 24;
    localparam int IN_IDX_LO = 0;
    localparam int IN_AMT_LO = IN_IDX_LO + IDX_F_W;
    localparam int IN_PAD_W  = IN_DATA_W - IDX_F_W - AMT_F_W;

    // output word layout
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - IDX_F_W - WASTE_F_W - TOTAL_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd2;

    // policy codes (unused code behaves as first fit)
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_COMMIT,
        ST_WIPE,
        ST_FINISH
    } t_state;

endpackage

[design/fit_policy_block_allocator_top.sv]
// Fit-policy block allocator: free-block table in memory with a sequential scan.
`include "fit_policy_block_allocator_top_defines.svh"

// The block keeps NUM_SLOTS memory blocks in two single-port-write tables held
// in synchronous RAM: a free bit per entry and a size per entry. Each input
// word carries a request in s_axis_tuser: clear (empty the table and zero the
// running waste), load (write a size at slot_index and mark it free; an index
// past the table is dropped) or allocate (ask for amount). fit_mode picks the
// policy for allocates: first fit, best fit or worst fit, ties to the lowest
// index; the granted entry leaves the table. Every input word gives exactly
// one output word: grant flag, slot, this grant's waste, and the saturating
// running waste total. An allocate reads the table one entry per clock, paced
// by the single read port of the table RAMs; a clear sweeps the free table one
// entry per clock. After reset the free table is swept once before
// s_axis_tready rises; fit_mode can be written during that pass. The finished
// word sits in an output register, so the next input is taken while it waits
// for m_axis_tready. Write fit_mode only while the block is idle.
module fit_policy_block_allocator_top #(
    parameter int NUM_SLOTS = fpba_pkg::NUM_SLOTS_DEF,
    parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: fit_mode
    input  logic                             i_cfg_we,
    input  logic [fpba_pkg::MODE_W-1:0]      i_cfg_wdata,
    // input words
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] slot_index, [21:6] amount, [23:22] zero
    input  logic [fpba_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] req_type
    input  logic [fpba_pkg::REQ_W-1:0]       s_axis_tuser,
    // result words
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] chosen_slot, [21:6] waste, [53:22] total_waste, [55:54] zero
    output logic [fpba_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] granted
    output logic [0:0]                       m_axis_tuser
);
    import fpba_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_SLOTS - 1);

    // table memories
    logic                 r_free_mem [NUM_SLOTS];
    logic [SIZE_BITS-1:0] r_size_mem [NUM_SLOTS];
    logic                 r_free_q;
    logic [SIZE_BITS-1:0] r_size_q;

    // control
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic                 r_dv;
    logic [IDX_W-1:0]     r_didx;
    logic [MODE_W-1:0]    r_mode;

    // current request and running pick
    logic [SIZE_BITS-1:0] r_amt;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_pick_size;

    // result and running total
    logic                 r_res_grant;
    logic [IDX_W-1:0]     r_res_slot;
    logic [SIZE_BITS-1:0] r_res_waste;
    logic [TOTAL_W-1:0]   r_sum;

    // output register
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                 r_out_grant;

    // decoded input
    logic                 in_acc;
    logic [IDX_F_W-1:0]   in_idx;
    logic [AMT_F_W-1:0]   in_amt;
    logic                 in_range;

    // memory write port
    logic                 free_we, free_wd, size_we;
    logic [IDX_W-1:0]     mem_wa;

    // scan and commit datapath
    logic                 fits, take;
    logic                 grant;
    logic [SIZE_BITS-1:0] waste;
    logic [TOTAL_W:0]     sum_ext;
    logic [TOTAL_W-1:0]   sum_sat;
    logic                 out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_idx   = s_axis_tdata[IN_IDX_LO +: IDX_F_W];
    assign in_amt   = s_axis_tdata[IN_AMT_LO +: AMT_F_W];
    assign in_range = (int'(in_idx) < NUM_SLOTS);
    assign out_free = !r_out_valid || m_axis_tready;

    // one table entry per cycle; strict compares keep the lowest index on ties
    always_comb begin
        fits = (r_size_q >= r_amt);
        case (r_mode)
            MODE_WORST: take = !r_found || (r_size_q > r_pick_size);
            MODE_BEST:  take = fits && (!r_found || (r_size_q < r_pick_size));
            default:    take = fits && !r_found;
        endcase
        take = take && r_dv && r_free_q;
    end

    // worst fit checks the size only after the scan
    assign grant   = r_found && ((r_mode != MODE_WORST) || (r_pick_size >= r_amt));
    assign waste   = r_pick_size - r_amt;
    assign sum_ext = {1'b0, r_sum} + (TOTAL_W + 1)'(waste);
    assign sum_sat = sum_ext[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_ext[TOTAL_W-1:0];

    // next state, next address, table writes
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        free_we = 1'b0;
        free_wd = 1'b0;
        size_we = 1'b0;
        mem_wa  = r_addr;
        case (r_state)
            ST_INIT, ST_WIPE: begin
                free_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_FINISH;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_addr = '0;
                    case (s_axis_tuser)
                        REQ_CLEAR: n_state = ST_WIPE;
                        REQ_LOAD: begin
                            n_state = ST_FINISH;
                            mem_wa  = IDX_W'(in_idx);
                            free_we = in_range;
                            free_wd = 1'b1;
                            size_we = in_range;
                        end
                        REQ_ALLOC: n_state = ST_SCAN;
                        default:   n_state = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = ST_SCAN_END;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_SCAN_END: n_state = ST_COMMIT;
            ST_COMMIT: begin
                n_state = ST_FINISH;
                mem_wa  = r_pick;
                free_we = grant;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // free table
    always_ff @(posedge i_clk) begin
        if (free_we) begin
            r_free_mem[mem_wa] <= free_wd;
        end
        r_free_q <= r_free_mem[r_addr];
    end

    // size table
    always_ff @(posedge i_clk) begin
        if (size_we) begin
            r_size_mem[mem_wa] <= SIZE_BITS'(in_amt);
        end
        r_size_q <= r_size_mem[r_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_dv        <= 1'b0;
            r_mode      <= MODE_FIRST;
            r_found     <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_dv    <= (r_state == ST_SCAN);
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_found <= 1'b0;
                if (s_axis_tuser == REQ_CLEAR) begin
                    r_sum <= '0;
                end
            end else if (take) begin
                r_found <= 1'b1;
            end
            if ((r_state == ST_COMMIT) && grant) begin
                r_sum <= sum_sat;
            end
            if ((r_state == ST_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_didx <= r_addr;
        if (in_acc) begin
            r_amt       <= SIZE_BITS'(in_amt);
            r_res_grant <= 1'b0;
            r_res_slot  <= '0;
            r_res_waste <= '0;
        end
        if (take) begin
            r_pick      <= r_didx;
            r_pick_size <= r_size_q;
        end
        if (r_state == ST_COMMIT) begin
            r_res_grant <= grant;
            r_res_slot  <= grant ? r_pick : '0;
            r_res_waste <= grant ? waste : '0;
        end
        if ((r_state == ST_FINISH) && out_free) begin
            r_out_grant <= r_res_grant;
            r_out_data  <= {{OUT_PAD_W{1'b0}}, r_sum,
                            WASTE_F_W'(r_res_waste), IDX_F_W'(r_res_slot)};
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_grant;

    // a grant never hands out a block smaller than the request
    `FPBA_ASSERT_NOW(a_grant_fits, (r_state == ST_COMMIT) && grant, r_pick_size >= r_amt, "grant smaller than request")
    // a result word only appears out of the finish step
    `FPBA_ASSERT_NOW(a_out_from_finish, $rose(r_out_valid), $past(r_state == ST_FINISH), "result word without finish")
    // a word without a grant carries no slot and no waste
    `FPBA_ASSERT_NOW(a_no_grant_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[IDX_F_W+WASTE_F_W-1:0] == '0, "ungranted word has slot or waste")
    // an accepted allocate starts the table scan at entry zero
    `FPBA_ASSERT_NEXT(a_alloc_scans, in_acc && (s_axis_tuser == REQ_ALLOC), (r_state == ST_SCAN) && (r_addr == '0), "allocate did not start scan")

endmodule
